// ===== hw/rtl/rv32d_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// RV32I decoder package
// Mnemonic codes, opcode values and the decoded result record shared by the
// decoder datapath and the top level.
// ----------------------------------------------------------------------------
package rv32d_pkg;

    typedef logic [5:0] mnem_t;
    typedef logic [6:0] opcode_t;

    // Dense mnemonic codes
    localparam mnem_t MN_LUI            = 6'd0;
    localparam mnem_t MN_AUIPC          = 6'd1;
    localparam mnem_t MN_JAL            = 6'd2;
    localparam mnem_t MN_JALR           = 6'd3;
    localparam mnem_t MN_BEQ            = 6'd4;
    localparam mnem_t MN_BNE            = 6'd5;
    localparam mnem_t MN_BLT            = 6'd6;
    localparam mnem_t MN_BGE            = 6'd7;
    localparam mnem_t MN_BLTU           = 6'd8;
    localparam mnem_t MN_BGEU           = 6'd9;
    localparam mnem_t MN_LB             = 6'd10;
    localparam mnem_t MN_LH             = 6'd11;
    localparam mnem_t MN_LW             = 6'd12;
    localparam mnem_t MN_LBU            = 6'd13;
    localparam mnem_t MN_LHU            = 6'd14;
    localparam mnem_t MN_SB             = 6'd15;
    localparam mnem_t MN_SH             = 6'd16;
    localparam mnem_t MN_SW             = 6'd17;
    localparam mnem_t MN_ADDI           = 6'd18;
    localparam mnem_t MN_SLTI           = 6'd19;
    localparam mnem_t MN_SLTIU          = 6'd20;
    localparam mnem_t MN_XORI           = 6'd21;
    localparam mnem_t MN_ORI            = 6'd22;
    localparam mnem_t MN_ANDI           = 6'd23;
    localparam mnem_t MN_SLLI           = 6'd24;
    localparam mnem_t MN_SRLI           = 6'd25;
    localparam mnem_t MN_SRAI           = 6'd26;
    localparam mnem_t MN_ADD            = 6'd27;
    localparam mnem_t MN_SUB            = 6'd28;
    localparam mnem_t MN_SLL            = 6'd29;
    localparam mnem_t MN_SLT            = 6'd30;
    localparam mnem_t MN_SLTU           = 6'd31;
    localparam mnem_t MN_XOR            = 6'd32;
    localparam mnem_t MN_SRL            = 6'd33;
    localparam mnem_t MN_SRA            = 6'd34;
    localparam mnem_t MN_OR             = 6'd35;
    localparam mnem_t MN_AND            = 6'd36;
    localparam mnem_t MN_ECALL          = 6'd37;
    localparam mnem_t MN_EBREAK         = 6'd38;
    localparam mnem_t MN_BRANCH_UNKNOWN = 6'd39;
    localparam mnem_t MN_WORD           = 6'd40;

    // Major opcodes
    localparam opcode_t OP_LOAD   = 7'h03;
    localparam opcode_t OP_IMM    = 7'h13;
    localparam opcode_t OP_AUIPC  = 7'h17;
    localparam opcode_t OP_STORE  = 7'h23;
    localparam opcode_t OP_REG    = 7'h33;
    localparam opcode_t OP_LUI    = 7'h37;
    localparam opcode_t OP_BRANCH = 7'h63;
    localparam opcode_t OP_JALR   = 7'h67;
    localparam opcode_t OP_JAL    = 7'h6F;
    localparam opcode_t OP_SYSTEM = 7'h73;

    localparam logic [6:0]  FUNCT7_ALT  = 7'h20;
    localparam logic [31:0] INSN_ECALL  = 32'h0000_0073;
    localparam logic [31:0] INSN_EBREAK = 32'h0010_0073;

    // One decoded instruction
    typedef struct packed {
        mnem_t       mnemonic;
        logic [4:0]  dest_reg;
        logic [4:0]  src_reg_a;
        logic [4:0]  src_reg_b;
        logic [11:0] small_imm;
        logic [19:0] upper_imm;
        logic [31:0] target_addr;
    } dec_result_t;

endpackage : rv32d_pkg
`default_nettype wire

// ===== hw/rtl/rv32d_decode.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// RV32I decode datapath
// Combinational decode of one instruction word into mnemonic, register
// numbers, immediate and branch/jump target.
// ----------------------------------------------------------------------------
module rv32d_decode (
    input  wire logic [31:0]          instr_word,
    input  wire logic [31:0]          pc_address,
    output rv32d_pkg::dec_result_t    result
);
    import rv32d_pkg::*;

    logic [6:0]  opcode;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [6:0]  f7;
    logic [11:0] imm_i;
    logic [11:0] imm_s;
    logic [11:0] shamt;
    logic [31:0] imm_b;
    logic [31:0] imm_j;
    logic [31:0] target;

    // Field extraction
    assign opcode = instr_word[6:0];
    assign rd     = instr_word[11:7];
    assign f3     = instr_word[14:12];
    assign rs1    = instr_word[19:15];
    assign rs2    = instr_word[24:20];
    assign f7     = instr_word[31:25];

    // Immediates
    assign imm_i = instr_word[31:20];
    assign imm_s = {instr_word[31:25], instr_word[11:7]};
    assign shamt = {7'd0, rs2};
    assign imm_b = {{19{instr_word[31]}}, instr_word[31], instr_word[7],
                    instr_word[30:25], instr_word[11:8], 1'b0};
    assign imm_j = {{11{instr_word[31]}}, instr_word[31], instr_word[19:12],
                    instr_word[20], instr_word[30:21], 1'b0};

    // Single shared target adder, wraps mod 2^32
    assign target = pc_address + ((opcode == OP_BRANCH) ? imm_b : imm_j);

    // Mnemonic and operand selection; unused fields stay zero
    always_comb
    begin
        result          = '0;
        result.mnemonic = MN_WORD;
        case (opcode)
            OP_LOAD:
            begin
                if (!(f3 inside {3'd3, 3'd6, 3'd7}))
                begin
                    case (f3)
                        3'd0:    result.mnemonic = MN_LB;
                        3'd1:    result.mnemonic = MN_LH;
                        3'd2:    result.mnemonic = MN_LW;
                        3'd4:    result.mnemonic = MN_LBU;
                        default: result.mnemonic = MN_LHU;
                    endcase
                    result.dest_reg  = rd;
                    result.src_reg_a = rs1;
                    result.small_imm = imm_i;
                end
            end
            OP_IMM:
            begin
                result.dest_reg  = rd;
                result.src_reg_a = rs1;
                result.small_imm = imm_i;
                case (f3)
                    3'd0: result.mnemonic = MN_ADDI;
                    3'd1:
                    begin
                        result.mnemonic  = MN_SLLI;
                        result.small_imm = shamt;
                    end
                    3'd2: result.mnemonic = MN_SLTI;
                    3'd3: result.mnemonic = MN_SLTIU;
                    3'd4: result.mnemonic = MN_XORI;
                    3'd5:
                    begin
                        result.mnemonic  = (f7 == FUNCT7_ALT) ? MN_SRAI : MN_SRLI;
                        result.small_imm = shamt;
                    end
                    3'd6:    result.mnemonic = MN_ORI;
                    default: result.mnemonic = MN_ANDI;
                endcase
            end
            OP_AUIPC:
            begin
                result.mnemonic  = MN_AUIPC;
                result.dest_reg  = rd;
                result.upper_imm = instr_word[31:12];
            end
            OP_STORE:
            begin
                if (f3 inside {3'd0, 3'd1, 3'd2})
                begin
                    case (f3)
                        3'd0:    result.mnemonic = MN_SB;
                        3'd1:    result.mnemonic = MN_SH;
                        default: result.mnemonic = MN_SW;
                    endcase
                    result.src_reg_a = rs1;
                    result.src_reg_b = rs2;
                    result.small_imm = imm_s;
                end
            end
            OP_REG:
            begin
                // only funct7 == 0x20 selects the alternate op
                case (f3)
                    3'd0:    result.mnemonic = (f7 == FUNCT7_ALT) ? MN_SUB : MN_ADD;
                    3'd1:    result.mnemonic = MN_SLL;
                    3'd2:    result.mnemonic = MN_SLT;
                    3'd3:    result.mnemonic = MN_SLTU;
                    3'd4:    result.mnemonic = MN_XOR;
                    3'd5:    result.mnemonic = (f7 == FUNCT7_ALT) ? MN_SRA : MN_SRL;
                    3'd6:    result.mnemonic = MN_OR;
                    default: result.mnemonic = MN_AND;
                endcase
                result.dest_reg  = rd;
                result.src_reg_a = rs1;
                result.src_reg_b = rs2;
            end
            OP_LUI:
            begin
                result.mnemonic  = MN_LUI;
                result.dest_reg  = rd;
                result.upper_imm = instr_word[31:12];
            end
            OP_BRANCH:
            begin
                case (f3)
                    3'd0:    result.mnemonic = MN_BEQ;
                    3'd1:    result.mnemonic = MN_BNE;
                    3'd4:    result.mnemonic = MN_BLT;
                    3'd5:    result.mnemonic = MN_BGE;
                    3'd6:    result.mnemonic = MN_BLTU;
                    3'd7:    result.mnemonic = MN_BGEU;
                    default: result.mnemonic = MN_BRANCH_UNKNOWN;
                endcase
                result.src_reg_a   = rs1;
                result.src_reg_b   = rs2;
                result.target_addr = target;
            end
            OP_JALR:
            begin
                result.mnemonic  = MN_JALR;
                result.dest_reg  = rd;
                result.src_reg_a = rs1;
                result.small_imm = imm_i;
            end
            OP_JAL:
            begin
                result.mnemonic    = MN_JAL;
                result.dest_reg    = rd;
                result.target_addr = target;
            end
            OP_SYSTEM:
            begin
                if (instr_word == INSN_ECALL)
                    result.mnemonic = MN_ECALL;
                else if (instr_word == INSN_EBREAK)
                    result.mnemonic = MN_EBREAK;
            end
            default:
            begin
                result.mnemonic = MN_WORD;
            end
        endcase
    end

endmodule : rv32d_decode
`default_nettype wire

// ===== hw/rtl/rv32i_instruction_decoder_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// RV32I instruction decoder, top level
// Input register, decode logic and result register with valid/stall flow
// control on both sides.
// ----------------------------------------------------------------------------
// One transfer in gives one decoded transfer out, via the input register and
// then the result register. The block takes a new instruction every cycle
// while in_stall is low: decode is a single pass of logic between the two
// registers, and the longest path is the 32-bit target adder. A stall on the
// output holds the result register, and the input side stalls only when both
// registers are full. Fields that an instruction does not use read as zero;
// undecodable words give mnemonic 40 and branches with funct3 2 or 3 give 39.
// ----------------------------------------------------------------------------
module rv32i_instruction_decoder_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // instruction channel
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [31:0]        instr_word,
    input  wire logic [31:0]        pc_address,
    // decoded channel
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [5:0]              mnemonic,
    output logic [4:0]              dest_reg,
    output logic [4:0]              src_reg_a,
    output logic [4:0]              src_reg_b,
    output logic signed [11:0]      small_imm,
    output logic [19:0]             upper_imm,
    output logic [31:0]             target_addr
);
    import rv32d_pkg::*;

    logic        in_vld_reg;
    logic [31:0] instr_reg;
    logic [31:0] pc_reg;
    logic        out_vld_reg;
    dec_result_t res_reg;
    dec_result_t res_next;
    logic        res_load;
    logic        in_load;

    // Flow control: result register advances when empty or being taken
    assign res_load = !out_vld_reg || !out_stall;
    assign in_load  = !in_vld_reg || res_load;
    assign in_stall = !in_load;

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_load)
                in_vld_reg <= in_valid;
            if (res_load)
                out_vld_reg <= in_vld_reg;
        end
    end

    // Input register
    always_ff @(posedge clk)
    begin
        if (in_load && in_valid)
        begin
            instr_reg <= instr_word;
            pc_reg    <= pc_address;
        end
    end

    rv32d_decode u_decode (
        .instr_word (instr_reg),
        .pc_address (pc_reg),
        .result     (res_next)
    );

    // Result register
    always_ff @(posedge clk)
    begin
        if (res_load && in_vld_reg)
            res_reg <= res_next;
    end

    // Output ports
    assign out_valid   = out_vld_reg;
    assign mnemonic    = res_reg.mnemonic;
    assign dest_reg    = res_reg.dest_reg;
    assign src_reg_a   = res_reg.src_reg_a;
    assign src_reg_b   = res_reg.src_reg_b;
    assign small_imm   = signed'(res_reg.small_imm);
    assign upper_imm   = res_reg.upper_imm;
    assign target_addr = res_reg.target_addr;

endmodule : rv32i_instruction_decoder_top
`default_nettype wire
